// ===== src/mbfp_pkg.sv =====
// Package for the MSB-first bit field packer.
// Holds the transaction types, the field limits and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps

package mbfp_pkg;

	localparam int MAX_FIELD_BITS = 32;
	localparam int FIELD_LIMIT = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;
	localparam int ACC_BITS = 40;
	localparam int CNT_BITS = 3;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] field_value;
		logic [5:0]  field_width;
	} item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [15:0] byte_index;
		logic        last;
	} result_t;

	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic load_empty;
		logic last_byte;
	} sts_t;

endpackage

// ===== src/mbfp_dpath.sv =====
// Datapath of the MSB-first bit field packer.
// Holds the bit accumulator, fill level, stream position and the result register.
// Depends on mbfp_pkg.
`timescale 1ns / 1ps

module mbfp_dpath
	import mbfp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cmd_t    cmd,
	output sts_t    sts,
	output result_t res
);

	logic [ACC_BITS-1:0] acc_q;
	logic [2:0]          fill_q;
	logic [15:0]         pos_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                flush_q;
	result_t             res_q;

	logic [5:0]          width_sat;
	logic [63:0]         mask_wide;
	logic [31:0]         masked;
	logic [5:0]          shift_amt;
	logic [71:0]         placed_wide;
	logic [ACC_BITS-1:0] acc_push;
	logic [5:0]          total;
	logic [CNT_BITS-1:0] load_cnt;

	always_comb begin
		width_sat = (item.field_width > 6'(FIELD_LIMIT)) ? 6'(FIELD_LIMIT) : item.field_width;
		mask_wide = (64'd1 << width_sat) - 64'd1;
		masked = item.field_value & mask_wide[31:0];
		shift_amt = 6'd40 - {3'b000, fill_q} - width_sat;
		placed_wide = {40'd0, masked} << shift_amt;
		acc_push = {acc_q[ACC_BITS-1:ACC_BITS-8], 32'd0} | placed_wide[ACC_BITS-1:0];
		total = {3'b000, fill_q} + width_sat;
		if (item.kind == KIND_FLUSH) begin
			load_cnt = (fill_q != 3'd0) ? 3'd1 : 3'd0;
		end else begin
			load_cnt = total[5:3];
		end
	end

	assign sts.load_empty = (load_cnt == 3'd0);
	assign sts.last_byte = (cnt_q == 3'd1);
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			fill_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
			flush_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q <= load_cnt;
			flush_q <= item.kind;
			if (item.kind == KIND_FLUSH) begin
				acc_q <= {acc_q[ACC_BITS-1:ACC_BITS-8], 32'd0};
				fill_q <= 3'd0;
				if (fill_q == 3'd0) begin
					pos_q <= 16'd0;
				end
			end else begin
				acc_q <= acc_push;
				fill_q <= total[2:0];
			end
		end else if (cmd.step) begin
			acc_q <= acc_q << 8;
			cnt_q <= cnt_q - 3'd1;
			pos_q <= flush_q ? 16'd0 : pos_q + 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			res_q.out_byte <= acc_q[ACC_BITS-1:ACC_BITS-8];
			res_q.byte_index <= pos_q;
			res_q.last <= (cnt_q == 3'd1);
		end
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("byte count out of range");
	a_step_drains: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && !cmd.load |=> cnt_q == $past(cnt_q) - 3'd1)
		else $error("step did not consume one byte");
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && item.kind == KIND_FLUSH |=> fill_q == 3'd0)
		else $error("flush left filled bits");
`endif

endmodule

// ===== src/mbfp_ctrl.sv =====
// Controller of the MSB-first bit field packer.
// Sequences load and byte emission and owns the handshake state.
// Depends on mbfp_pkg.
`timescale 1ns / 1ps

module mbfp_ctrl
	import mbfp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	output logic res_valid,
	input  logic res_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic res_valid_q;
	logic can_step;

	assign item_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign can_step = !res_valid_q || !res_stall;
	assign cmd.load = (state_q == ST_IDLE) && item_valid;
	assign cmd.step = (state_q == ST_EMIT) && can_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.load && !sts.load_empty) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.step && sts.last_byte) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_step_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> res_valid)
		else $error("emitted byte not presented");
	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && sts.last_byte |=> state_q == ST_IDLE)
		else $error("controller stayed busy after last byte");
	a_empty_stays: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && sts.load_empty |=> state_q == ST_IDLE)
		else $error("controller busy on a transaction with no bytes");
`endif

endmodule

// ===== src/msb_first_bit_field_packer.sv =====
// Top level of the MSB-first bit field packer.
// Joins the controller and the datapath. Depends on mbfp_pkg, mbfp_ctrl and mbfp_dpath.
//
// Usage: the input channel (item_valid, item_stall, item) carries push and flush
// transactions; the output channel (res_valid, res_stall, res) carries one byte per
// transaction on the output, with last set on the final byte of each input transaction.
// A push appends the low field_width bits of field_value, most significant first, and
// emits every byte it completes, from zero to four. A flush emits the partial byte,
// zero padded, if any bits are pending, and restarts the stream at position zero.
// Timing: an input transaction is loaded into the accumulator and its bytes then leave one
// per cycle through the output register while the receiver does not stall, so the input
// stays busy while they drain; a transaction producing no bytes does not stall the input.
// The single byte emission path sets this rate.
// Stalls: while the receiver stalls, the output register holds its byte and emission
// pauses; item_stall stays high until the last byte has entered the output register.
// Reset: arst_n clears the pending bits, the fill level and the position to zero.
`timescale 1ns / 1ps

module msb_first_bit_field_packer
	import mbfp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    res_valid,
	input  logic    res_stall,
	output result_t res
);

	cmd_t cmd;
	sts_t sts;

	mbfp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	mbfp_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

endmodule

// ===== sim/tb_msb_first_bit_field_packer.sv =====
// Self-checking testbench for the MSB-first bit field packer.
// Drives push and flush transactions with random gaps and stalls, predicts every packed byte.
// Depends on mbfp_pkg and msb_first_bit_field_packer.
`timescale 1ns / 1ps

module tb_msb_first_bit_field_packer;
	import mbfp_pkg::*;

	typedef struct {
		item_t       payload;
		int unsigned gap;
	} queued_item_t;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    res_valid;
	logic    res_stall = 1'b0;
	result_t res;

	queued_item_t pending_items[$];
	result_t      expected_bytes[$];
	int unsigned  mismatch_count = 0;

	// Predicted packing state.
	logic [7:0]  acc_byte = '0;
	int unsigned acc_bits = 0;
	logic [15:0] stream_pos = '0;

	int unsigned tx_mode = 0;
	int unsigned tx_left = 0;
	int unsigned rx_mode = 0;
	int unsigned rx_left = 0;
	int unsigned stall_left = 0;

	msb_first_bit_field_packer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void pack_into_bytes(input item_t it);
		result_t made [4];
		int      n;
		int      w;
		n = 0;
		if (it.kind == KIND_FLUSH) begin
			if (acc_bits != 0) begin
				made[0] = '{out_byte: acc_byte, byte_index: stream_pos, last: 1'b0};
				n = 1;
			end
			acc_byte = '0;
			acc_bits = 0;
			stream_pos = '0;
		end else begin
			w = (int'(it.field_width) > FIELD_LIMIT) ? FIELD_LIMIT : int'(it.field_width);
			for (int i = w - 1; i >= 0; i--) begin
				acc_byte[7 - acc_bits] = it.field_value[i];
				acc_bits++;
				if (acc_bits == 8) begin
					if (n < 4)
						made[n] = '{out_byte: acc_byte, byte_index: stream_pos, last: 1'b0};
					n++;
					acc_byte = '0;
					acc_bits = 0;
					stream_pos = stream_pos + 16'd1;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			made[k].last = (k == n - 1);
			expected_bytes.push_back(made[k]);
		end
	endfunction

	function automatic int unsigned next_gap();
		if (tx_left == 0) begin
			tx_mode = $urandom_range(0, 2);
			tx_left = $urandom_range(10, 40);
		end
		tx_left--;
		case (tx_mode)
			0: return 0;
			1: return $urandom_range(0, 14);
			default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
		endcase
	endfunction

	function automatic int unsigned next_stall();
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(10, 60);
		end
		rx_left--;
		case (rx_mode)
			0: return 0;
			1: return $urandom_range(0, 14);
			default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
		endcase
	endfunction

	function automatic void add_item(input logic kind, input logic [31:0] value,
			input logic [5:0] width, input int unsigned gap);
		queued_item_t q;
		q.payload.kind = kind;
		q.payload.field_value = value;
		q.payload.field_width = width;
		q.gap = gap;
		pending_items.push_back(q);
	endfunction

	function automatic void add_random_item();
		logic [5:0] width;
		case ($urandom_range(0, 9))
			0: width = 6'd32;
			1: width = 6'($urandom_range(33, 63));
			default: width = 6'($urandom_range(0, 32));
		endcase
		add_item(($urandom_range(0, 11) == 0) ? KIND_FLUSH : KIND_PUSH, $urandom, width,
			next_gap());
	endfunction

	task automatic drain();
		while (pending_items.size() != 0 || item_valid || expected_bytes.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && !item_stall)
				pack_into_bytes(item);
			if (!item_valid || !item_stall) begin
				if (pending_items.size() == 0) begin
					item_valid <= 1'b0;
				end else if (pending_items[0].gap != 0) begin
					pending_items[0].gap--;
					item_valid <= 1'b0;
				end else begin
					item <= pending_items[0].payload;
					item_valid <= 1'b1;
					void'(pending_items.pop_front());
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_bytes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected byte %02h index %0d last %0b",
							res.out_byte, res.byte_index, res.last);
				end else begin
					if (res.out_byte !== expected_bytes[0].out_byte ||
							res.byte_index !== expected_bytes[0].byte_index ||
							res.last !== expected_bytes[0].last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("byte %02h index %0d last %0b, got %02h index %0d last %0b",
								expected_bytes[0].out_byte, expected_bytes[0].byte_index,
								expected_bytes[0].last, res.out_byte, res.byte_index, res.last);
					end
					void'(expected_bytes.pop_front());
				end
				stall_left = next_stall();
			end else if (stall_left != 0) begin
				stall_left--;
			end
			res_stall <= (stall_left != 0);
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		add_item(KIND_PUSH, 32'hFFFF_FFFF, 6'd0, 0);
		add_item(KIND_FLUSH, 32'h0000_0000, 6'd0, 0);
		add_item(KIND_PUSH, 32'hFFFF_FFFF, 6'd32, 0);
		add_item(KIND_PUSH, 32'h0000_0000, 6'd32, 3);
		add_item(KIND_PUSH, 32'h0000_0001, 6'd1, 0);
		add_item(KIND_PUSH, 32'hFFFF_FF55, 6'd7, 0);
		add_item(KIND_PUSH, 32'h0000_0005, 6'd3, 2);
		add_item(KIND_FLUSH, 32'h1234_5678, 6'd17, 0);
		add_item(KIND_PUSH, 32'hA5A5_A5A5, 6'd33, 0);
		add_item(KIND_PUSH, 32'h1234_5678, 6'd63, 0);
		add_item(KIND_PUSH, 32'hFFFF_FFF5, 6'd5, 1);
		add_item(KIND_PUSH, 32'h89AB_CDEF, 6'd32, 0);
		add_item(KIND_FLUSH, 32'hFFFF_FFFF, 6'd63, 0);
		add_item(KIND_PUSH, 32'hFFFF_FF00, 6'd8, 0);
		add_item(KIND_PUSH, 32'h7FFF_FFFF, 6'd31, 0);
		add_item(KIND_PUSH, 32'h0000_0001, 6'd1, 0);
		add_item(KIND_FLUSH, 32'h0000_0000, 6'd32, 0);
		add_item(KIND_PUSH, 32'h0000_BEEF, 6'd16, 4);
		add_item(KIND_PUSH, 32'hC3C3_C3C3, 6'd40, 0);
		add_item(KIND_PUSH, 32'h0000_0002, 6'd2, 0);
		add_item(KIND_FLUSH, 32'h0000_0000, 6'd0, 0);
		add_item(KIND_FLUSH, 32'h0000_0000, 6'd0, 0);
		repeat (265) add_random_item();
		add_item(KIND_FLUSH, $urandom, 6'($urandom_range(0, 63)), next_gap());
		drain();

		repeat (20) add_random_item();
		add_item(KIND_FLUSH, $urandom, 6'($urandom_range(0, 63)), next_gap());
		drain();

		repeat (20) @(negedge clk);
		mismatch_count += expected_bytes.size();
		if (mismatch_count == 0)
			$display("msb_first_bit_field_packer: match");
		else
			$display("msb_first_bit_field_packer: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("msb_first_bit_field_packer: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
src/mbfp_pkg.sv
src/mbfp_dpath.sv
src/mbfp_ctrl.sv
src/msb_first_bit_field_packer.sv
sim/tb_msb_first_bit_field_packer.sv
